// ===== rtl/rtpslt_pkg.sv =====
`default_nettype none
package rtpslt_pkg;

	localparam int WIN_DEPTH = 1024;
	localparam int WIN_AW = $clog2(WIN_DEPTH);
	localparam int CNT_W = 48;
	localparam int EXT_W = 33;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
	localparam logic [16:0] PROBE_NONE = 17'h10001;

	localparam logic [0:0] REG_MAX_DROPOUT = 1'b0;
	localparam logic [0:0] REG_MAX_MISORDER = 1'b1;

	typedef enum logic [2:0] {
		CLS_FIRST   = 3'd0,
		CLS_ORDER   = 3'd1,
		CLS_DUP     = 3'd2,
		CLS_LATE    = 3'd3,
		CLS_PROBE   = 3'd4,
		CLS_RESTART = 3'd5
	} cls_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic             start;
		logic             clear;
		logic             put;
		logic [EXT_W-1:0] key;
	} win_req_t;

	typedef struct packed {
		logic done;
		logic hit;
	} win_stat_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/rtpslt_if.sv =====
`default_nettype none
interface rtpslt_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] sequence_number;
	logic [31:0] rtp_timestamp;
	logic [6:0]  payload_kind;
	logic [15:0] payload_length;

	modport source (output valid, sequence_number, rtp_timestamp, payload_kind,
		payload_length, input ready);
	modport sink (input valid, sequence_number, rtp_timestamp, payload_kind,
		payload_length, output ready);
endinterface

interface rtpslt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  packet_class;
	logic [32:0] expected_count;
	logic [47:0] received_count;
	logic [48:0] lost_count;
	logic [47:0] reordered_count;
	logic [47:0] duplicate_count;
	logic [47:0] restart_count;
	logic [47:0] kind_changes;
	logic [47:0] length_changes;
	logic [47:0] step_changes;
	logic [31:0] current_step;
	logic [2:0]  change_flags;

	modport source (output valid, packet_class, expected_count, received_count,
		lost_count, reordered_count, duplicate_count, restart_count, kind_changes,
		length_changes, step_changes, current_step, change_flags, input ready);
	modport sink (input valid, packet_class, expected_count, received_count,
		lost_count, reordered_count, duplicate_count, restart_count, kind_changes,
		length_changes, step_changes, current_step, change_flags, output ready);
endinterface

interface rtpslt_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rtpslt_ram.sv =====
`default_nettype none
module rtpslt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/rtpslt_window.sv =====
`default_nettype none
module rtpslt_window (
	input  wire                   clk,
	input  wire                   arst_n,
	input  rtpslt_pkg::win_req_t  req,
	output rtpslt_pkg::win_stat_t stat
);
	import rtpslt_pkg::*;

	logic [WIN_AW-1:0] head_q;
	logic [WIN_AW:0]   fill_q;
	logic [WIN_AW:0]   idx_q;
	logic              busy_q;
	logic              pend_s1;
	logic              hit_q;
	logic              done_q;
	logic              issue;
	logic [EXT_W-1:0]  rdata;

	assign issue = busy_q && (idx_q < fill_q);

	rtpslt_ram #(.WIDTH(EXT_W), .DEPTH(WIN_DEPTH)) u_ram (
		.clk   (clk),
		.we    (req.put),
		.waddr (head_q),
		.wdata (req.key),
		.raddr (idx_q[WIN_AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (req.clear) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (req.put) begin
			head_q <= head_q + 1'b1;
			if (fill_q < (WIN_AW+1)'(WIN_DEPTH)) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
			done_q  <= 1'b0;
		end else if (req.start) begin
			busy_q  <= 1'b1;
			idx_q   <= '0;
			pend_s1 <= 1'b0;
			hit_q   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			pend_s1 <= issue;
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (pend_s1 && rdata == req.key) begin
				hit_q <= 1'b1;
			end
			if (busy_q && !issue && !pend_s1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign stat = {done_q, hit_q};
endmodule
`default_nettype wire

// ===== rtl/rtp_sequence_loss_tracker_unit.sv =====
// RTP sequence loss tracker, one source.
// pkt: one request per RTP packet header (sequence number, timestamp,
//   payload type, payload size). res: one result request per packet with
//   the class and all running counts. cfg: register writes (index 0
//   max_dropout, index 1 max_misorder), always ready; the user writes
//   only while idle, which the block itself does not enforce.
// A searched packet is compared with every entry of the seen window (up
// to 1024), one per cycle through the window memory's single read port.
// First, restart and probe packets skip the search. One packet
// is worked on at a time; pkt.ready is high only while the tracker is idle.
// The result sits in an output register; a stalled receiver holds it and
// the next packet may be accepted meanwhile, but its result waits until the
// register is free.
// Reset clears all sequence state and counters, empties the window through
// its fill count (no clearing pass) and sets max_dropout 3000 and
// max_misorder 100.
`default_nettype none
module rtp_sequence_loss_tracker_unit (
	input wire           clk,
	input wire           arst_n,
	rtpslt_in_if.sink    pkt,
	rtpslt_out_if.source res,
	rtpslt_cfg_if.sink   cfg
);
	import rtpslt_pkg::*;

	state_t state_q, state_d;

	logic [15:0] max_dropout_q, max_misorder_q;
	logic [15:0] seq_q, len_q;
	logic [31:0] ts_q;
	logic [6:0]  kind_q;

	logic             active_q;
	logic [15:0]      base_q, high_q;
	logic [31:0]      wrap_q;
	logic [16:0]      probe_q;
	logic [CNT_W-1:0] recv_q, reord_q, dup_q, rst_q, kchg_q, lchg_q, schg_q;
	logic [6:0]       last_kind_q;
	logic [15:0]      last_len_q, prev_seq_q;
	logic [31:0]      step_q, prev_ts_q;
	logic             have_prev_q;

	cls_t             cls_q;
	logic [EXT_W-1:0] ext_q;
	logic             search_q, put_q;

	win_req_t  wreq;
	win_stat_t wstat;

	logic accept, load, out_free;

	rtpslt_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (wreq),
		.stat   (wstat)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dropout_q  <= 16'd3000;
			max_misorder_q <= 16'd100;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MAX_DROPOUT:  max_dropout_q <= cfg.data;
				REG_MAX_MISORDER: max_misorder_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// eval-stage decode
	logic [15:0]      udelta;
	logic             in_order, not_late;
	logic [31:0]      wrap_next;
	logic [EXT_W-1:0] ext_raw, ext_hi;

	always_comb begin
		udelta    = seq_q - high_q;
		in_order  = udelta < max_dropout_q;
		not_late  = {1'b0, udelta} <= (17'h10000 - {1'b0, max_misorder_q});
		wrap_next = wrap_q + ((seq_q < high_q) ? 32'h10000 : 32'h0);
		ext_raw   = {1'b0, wrap_q} + {17'b0, seq_q};
		ext_hi    = {1'b0, wrap_q} + {17'b0, high_q};
	end

	logic search_sel;
	assign search_sel = active_q && (in_order || !not_late);

	// done-stage update
	logic             hit;
	cls_t             cls_d;
	logic [CNT_W-1:0] recv_d, reord_d, dup_d, kchg_d, lchg_d, schg_d;
	logic [31:0]      step_d, stp;
	logic [2:0]       flags_d;
	logic [EXT_W-1:0] expected;
	logic [48:0]      lost;

	always_comb begin
		hit     = search_q && wstat.hit;
		cls_d   = hit ? CLS_DUP : cls_q;
		recv_d  = sat_inc(recv_q);
		dup_d   = hit ? sat_inc(dup_q) : dup_q;
		reord_d = (cls_q == CLS_LATE && !hit) ? sat_inc(reord_q) : reord_q;
		flags_d = 3'b000;
		kchg_d  = kchg_q;
		lchg_d  = lchg_q;
		schg_d  = schg_q;
		step_d  = step_q;
		stp     = ts_q - prev_ts_q;
		if (kind_q != last_kind_q) begin
			kchg_d     = sat_inc(kchg_q);
			flags_d[0] = 1'b1;
		end
		if (len_q != last_len_q) begin
			lchg_d     = sat_inc(lchg_q);
			flags_d[1] = 1'b1;
		end
		if (have_prev_q && seq_q == prev_seq_q + 16'd1) begin
			if (step_q == 32'd0) begin
				step_d = stp;
			end else if (stp != step_q) begin
				schg_d     = sat_inc(schg_q);
				step_d     = stp;
				flags_d[2] = 1'b1;
			end
		end
		expected = ext_hi - {17'b0, base_q} + 33'd1;
		lost     = {16'b0, expected} - {1'b0, recv_d};
	end

	assign out_free = !res.valid || res.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (pkt.valid) state_d = ST_EVAL;
			ST_EVAL: state_d = search_sel ? ST_SCAN : ST_DONE;
			ST_SCAN: if (wstat.done) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	logic clear_win;
	always_comb begin
		clear_win = !active_q || (!in_order && not_late && {1'b0, seq_q} == probe_q);
		pkt.ready = (state_q == ST_IDLE);
		accept    = pkt.valid && (state_q == ST_IDLE);
		load      = (state_q == ST_DONE) && out_free;
		wreq.start = (state_q == ST_EVAL) && search_sel;
		wreq.clear = (state_q == ST_EVAL) && clear_win;
		wreq.put   = load && put_q && !hit;
		wreq.key   = ext_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seq_q  <= pkt.sequence_number;
			ts_q   <= pkt.rtp_timestamp;
			kind_q <= pkt.payload_kind;
			len_q  <= pkt.payload_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			base_q      <= '0;
			high_q      <= '0;
			wrap_q      <= '0;
			probe_q     <= PROBE_NONE;
			recv_q      <= '0;
			reord_q     <= '0;
			dup_q       <= '0;
			rst_q       <= '0;
			kchg_q      <= '0;
			lchg_q      <= '0;
			schg_q      <= '0;
			last_kind_q <= '0;
			last_len_q  <= '0;
			step_q      <= '0;
			prev_seq_q  <= '0;
			prev_ts_q   <= '0;
			have_prev_q <= 1'b0;
			cls_q       <= CLS_FIRST;
			ext_q       <= '0;
			search_q    <= 1'b0;
			put_q       <= 1'b0;
		end else if (state_q == ST_EVAL) begin
			search_q <= search_sel;
			put_q    <= 1'b1;
			if (!active_q) begin
				active_q    <= 1'b1;
				base_q      <= seq_q;
				high_q      <= seq_q;
				wrap_q      <= '0;
				probe_q     <= PROBE_NONE;
				recv_q      <= '0;
				last_kind_q <= kind_q;
				last_len_q  <= len_q;
				ext_q       <= {17'b0, seq_q};
				cls_q       <= CLS_FIRST;
			end else if (in_order) begin
				wrap_q  <= wrap_next;
				high_q  <= seq_q;
				ext_q   <= {1'b0, wrap_next} + {17'b0, seq_q};
				cls_q   <= CLS_ORDER;
			end else if (not_late) begin
				if ({1'b0, seq_q} == probe_q) begin
					base_q  <= seq_q;
					high_q  <= seq_q;
					wrap_q  <= '0;
					probe_q <= PROBE_NONE;
					recv_q  <= '0;
					rst_q   <= sat_inc(rst_q);
					ext_q   <= {17'b0, seq_q};
					cls_q   <= CLS_RESTART;
				end else begin
					probe_q <= {1'b0, seq_q + 16'd1};
					reord_q <= sat_inc(reord_q);
					put_q   <= 1'b0;
					cls_q   <= CLS_PROBE;
				end
			end else begin
				ext_q <= (ext_raw > ext_hi) ? ext_raw - 33'h10000 : ext_raw;
				cls_q <= CLS_LATE;
			end
		end else if (load) begin
			recv_q      <= recv_d;
			reord_q     <= reord_d;
			dup_q       <= dup_d;
			kchg_q      <= kchg_d;
			lchg_q      <= lchg_d;
			schg_q      <= schg_d;
			step_q      <= step_d;
			last_kind_q <= kind_q;
			last_len_q  <= len_q;
			prev_seq_q  <= seq_q;
			prev_ts_q   <= ts_q;
			have_prev_q <= 1'b1;
		end
	end

	logic out_valid_q;
	assign res.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res.packet_class    <= cls_d;
			res.expected_count  <= expected;
			res.received_count  <= recv_d;
			res.lost_count      <= lost;
			res.reordered_count <= reord_d;
			res.duplicate_count <= dup_d;
			res.restart_count   <= rst_q;
			res.kind_changes    <= kchg_d;
			res.length_changes  <= lchg_d;
			res.step_changes    <= schg_d;
			res.current_step    <= step_d;
			res.change_flags    <= flags_d;
		end
	end
endmodule
`default_nettype wire
